[rtl/wav_riff_header_parser_macros.svh]
// ----------------------------------------------------------------------------
// wav riff header parser assertion macros
// shared assertion shorthands for the parser rtl
// ----------------------------------------------------------------------------
`ifndef WAV_RIFF_HEADER_PARSER_MACROS_SVH
`define WAV_RIFF_HEADER_PARSER_MACROS_SVH

// implication checked on every clock edge outside reset
`define WRH_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked on the next clock edge
`define WRH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/wrh_pkg.sv]
// ----------------------------------------------------------------------------
// wrh_pkg
// types and constants shared by the wav riff header parser
// ----------------------------------------------------------------------------
package wrh_pkg;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  sample_byte;
        logic        sample_valid;
        logic [2:0]  parse_status;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [15:0] valid_sample_bits;
        logic [31:0] speaker_mask;
        logic [31:0] frame_total;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_FACT = 32'h7463_6166;
    localparam logic [15:0] EXT_TAG  = 16'hFFFE;
    localparam logic [15:0] EXT_MIN  = 16'd22;

    localparam logic [2:0] ST_PARSING = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_BAD_RIFF = 3'd2;
    localparam logic [2:0] ST_BAD_WAVE = 3'd3;
    localparam logic [2:0] ST_NO_FMT  = 3'd4;
    localparam logic [2:0] ST_NO_DATA = 3'd5;
    localparam logic [2:0] ST_UNSUP   = 3'd6;

endpackage

[rtl/wrh_divider.sv]
// ----------------------------------------------------------------------------
// wrh_divider
// radix-2 restoring divider, one quotient bit per cycle, zero divisor gives 0
// ----------------------------------------------------------------------------
module wrh_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  wrh_pkg::div_req_t req,
    output wrh_pkg::div_rsp_t rsp
);

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [16:0] trial;

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg[15:0], quo_reg[31]};
        if (req.start) begin
            busy_next = (req.divisor != 16'd0);
            done_next = (req.divisor == 16'd0);
            quo_next  = (req.divisor == 16'd0) ? 32'd0 : req.dividend;
            rem_next  = 17'd0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd32;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/wav_riff_header_parser.sv]
// ----------------------------------------------------------------------------
// wav_riff_header_parser
// byte-serial riff/wave header parser with pcm sample pass-through
// ----------------------------------------------------------------------------
// s_ channel: one file byte per transaction, final_byte marks the last byte.
// m_ channel: one result per input byte carrying the pass-through sample,
// the parse status and the current format fields.
// a byte is decoded in the cycle it is accepted and its result is registered;
// the next byte is taken once that result has been taken.
// when a data chunk ends, or the file ends inside one, the frame count is
// data bytes divided by block_align, computed by a bit-serial divider;
// the result of that byte waits for the quotient before it is offered.
// after a nonzero status every later byte is absorbed with fields held.
// a stalled receiver holds the result and the input stays not ready.
// reset (aresetn low, synchronous) returns to expecting the riff tag with all
// format fields cleared.
// ----------------------------------------------------------------------------
`include "wav_riff_header_parser_macros.svh"

module wav_riff_header_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wrh_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output wrh_pkg::out_item_t m_data
);

    localparam logic [3:0] PH_RIFF  = 4'd0;
    localparam logic [3:0] PH_RSIZE = 4'd1;
    localparam logic [3:0] PH_WAVE  = 4'd2;
    localparam logic [3:0] PH_CID   = 4'd3;
    localparam logic [3:0] PH_CSIZE = 4'd4;
    localparam logic [3:0] PH_FMT   = 4'd5;
    localparam logic [3:0] PH_FACT  = 4'd6;
    localparam logic [3:0] PH_DATA  = 4'd7;
    localparam logic [3:0] PH_SKIP  = 4'd8;
    localparam logic [3:0] PH_PAD   = 4'd9;
    localparam logic [3:0] PH_STOP  = 4'd10;

    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_DIV  = 2'd1;
    localparam logic [1:0] SQ_OUT  = 2'd2;

    logic [1:0]  sq_reg, sq_next;
    logic [3:0]  ph_reg, ph_next;
    logic [31:0] bif_reg, bif_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] clen_reg, clen_next;
    logic [31:0] fsh_reg, fsh_next;
    logic [15:0] xsz_reg, xsz_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic        data_seen_reg, data_seen_next;
    logic [31:0] dbytes_reg, dbytes_next;
    logic [2:0]  st_reg, st_next;
    logic [15:0] ftag_reg, ftag_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic [15:0] vbits_reg, vbits_next;
    logic [31:0] mask_reg, mask_next;
    logic [31:0] frames_reg, frames_next;
    logic [7:0]  sbyte_reg, sbyte_next;
    logic        svalid_reg, svalid_next;

    logic        accept;
    logic        need_div;
    logic [31:0] bif_inc;
    logic [1:0]  lane;
    logic [7:0]  b;
    logic        ext;

    wrh_pkg::div_req_t div_req;
    wrh_pkg::div_rsp_t div_rsp;

    wrh_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready = (sq_reg == SQ_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = (sq_reg == SQ_OUT);

    always_comb begin
        ph_next        = ph_reg;
        bif_next       = bif_reg;
        tag_next       = tag_reg;
        clen_next      = clen_reg;
        fsh_next       = fsh_reg;
        xsz_next       = xsz_reg;
        fmt_seen_next  = fmt_seen_reg;
        data_seen_next = data_seen_reg;
        dbytes_next    = dbytes_reg;
        st_next        = st_reg;
        ftag_next      = ftag_reg;
        chan_next      = chan_reg;
        rate_next      = rate_reg;
        brate_next     = brate_reg;
        align_next     = align_reg;
        bits_next      = bits_reg;
        vbits_next     = vbits_reg;
        mask_next      = mask_reg;
        frames_next    = frames_reg;
        sbyte_next     = sbyte_reg;
        svalid_next    = svalid_reg;
        need_div       = 1'b0;
        b              = s_data.file_byte;
        bif_inc        = bif_reg + 32'd1;
        lane           = bif_reg[1:0];
        ext            = (ftag_reg == wrh_pkg::EXT_TAG) && (xsz_reg >= wrh_pkg::EXT_MIN);

        if (accept) begin
            sbyte_next  = 8'd0;
            svalid_next = 1'b0;
            if (ph_reg != PH_STOP) begin
                unique case (ph_reg)
                    PH_RIFF, PH_WAVE, PH_CID: begin
                        tag_next[lane*8 +: 8] = b;
                        bif_next = bif_inc;
                        if (bif_inc == 32'd4) begin
                            bif_next = 32'd0;
                            if (ph_reg == PH_RIFF) begin
                                if (tag_next != wrh_pkg::TAG_RIFF) begin
                                    st_next = wrh_pkg::ST_BAD_RIFF;
                                    ph_next = PH_STOP;
                                end else begin
                                    ph_next = PH_RSIZE;
                                end
                                tag_next = 32'd0;
                            end else if (ph_reg == PH_WAVE) begin
                                if (tag_next != wrh_pkg::TAG_WAVE) begin
                                    st_next = wrh_pkg::ST_BAD_WAVE;
                                    ph_next = PH_STOP;
                                end else begin
                                    ph_next = PH_CID;
                                end
                                tag_next = 32'd0;
                            end else begin
                                fsh_next = 32'd0;
                                ph_next  = PH_CSIZE;
                            end
                        end
                    end
                    PH_RSIZE: begin
                        bif_next = bif_inc;
                        if (bif_inc == 32'd4) begin
                            bif_next = 32'd0;
                            ph_next  = PH_WAVE;
                        end
                    end
                    PH_CSIZE: begin
                        fsh_next[lane*8 +: 8] = b;
                        bif_next = bif_inc;
                        if (bif_inc == 32'd4) begin
                            clen_next = fsh_next;
                            bif_next  = 32'd0;
                            if (tag_reg == wrh_pkg::TAG_FMT) begin
                                fmt_seen_next = 1'b1;
                                ftag_next = 16'd0; chan_next = 16'd0; rate_next = 32'd0;
                                brate_next = 32'd0; align_next = 16'd0; bits_next = 16'd0;
                                vbits_next = 16'd0; mask_next = 32'd0; frames_next = 32'd0;
                                xsz_next = 16'd0;
                                ph_next = PH_FMT;
                            end else if (tag_reg == wrh_pkg::TAG_DATA) begin
                                data_seen_next = 1'b1;
                                if (!fmt_seen_reg) begin
                                    st_next = wrh_pkg::ST_NO_FMT;
                                    ph_next = PH_STOP;
                                end else if (ftag_reg != 16'd1 ||
                                        (bits_reg != 16'd8 && bits_reg != 16'd16 &&
                                         bits_reg != 16'd24 && bits_reg != 16'd32)) begin
                                    st_next = wrh_pkg::ST_UNSUP;
                                    ph_next = PH_STOP;
                                end else begin
                                    dbytes_next = 32'd0;
                                    ph_next = PH_DATA;
                                end
                            end else if (tag_reg == wrh_pkg::TAG_FACT) begin
                                frames_next = 32'd0;
                                ph_next = PH_FACT;
                            end else begin
                                ph_next = PH_SKIP;
                            end
                            if (ph_next != PH_STOP && fsh_next == 32'd0) begin
                                if (ph_next == PH_DATA) need_div = 1'b1;
                                tag_next = 32'd0;
                                ph_next  = PH_CID;
                            end
                        end
                    end
                    PH_PAD: begin
                        ph_next  = PH_CID;
                        bif_next = 32'd0;
                        tag_next = 32'd0;
                    end
                    PH_FMT, PH_FACT, PH_DATA, PH_SKIP: begin
                        if (ph_reg == PH_FMT) begin
                            if (bif_reg < 32'd2) ftag_next[bif_reg[0]*8 +: 8] = b;
                            else if (bif_reg < 32'd4) chan_next[bif_reg[0]*8 +: 8] = b;
                            else if (bif_reg < 32'd8) rate_next[lane*8 +: 8] = b;
                            else if (bif_reg < 32'd12) brate_next[lane*8 +: 8] = b;
                            else if (bif_reg < 32'd14) align_next[bif_reg[0]*8 +: 8] = b;
                            else if (bif_reg < 32'd16) bits_next[bif_reg[0]*8 +: 8] = b;
                            else if (bif_reg < 32'd18) xsz_next[bif_reg[0]*8 +: 8] = b;
                            else if (bif_reg < 32'd20) begin
                                if (ext) vbits_next[bif_reg[0]*8 +: 8] = b;
                            end else if (bif_reg < 32'd24) begin
                                if (ext) mask_next[lane*8 +: 8] = b;
                            end
                        end else if (ph_reg == PH_FACT) begin
                            if (bif_reg < 32'd4) frames_next[lane*8 +: 8] = b;
                        end else if (ph_reg == PH_DATA) begin
                            sbyte_next  = b;
                            svalid_next = 1'b1;
                            dbytes_next = dbytes_reg + 32'd1;
                        end
                        bif_next = bif_inc;
                        if (bif_inc == clen_reg) begin
                            if (ph_reg == PH_DATA) need_div = 1'b1;
                            bif_next = 32'd0;
                            tag_next = 32'd0;
                            ph_next  = clen_reg[0] ? PH_PAD : PH_CID;
                        end
                    end
                    default: begin
                        ph_next = ph_reg;
                    end
                endcase

                if (s_data.final_byte && st_next == wrh_pkg::ST_PARSING) begin
                    if (ph_next == PH_RIFF) st_next = wrh_pkg::ST_BAD_RIFF;
                    else if (ph_next == PH_RSIZE || ph_next == PH_WAVE)
                        st_next = wrh_pkg::ST_BAD_WAVE;
                    else begin
                        if (ph_next == PH_DATA) need_div = 1'b1;
                        st_next = !fmt_seen_next ? wrh_pkg::ST_NO_FMT :
                                  (!data_seen_next ? wrh_pkg::ST_NO_DATA : wrh_pkg::ST_DONE);
                    end
                    ph_next = PH_STOP;
                end
            end
        end

        if (div_rsp.done) frames_next = div_rsp.quotient;
    end

    assign div_req.start    = accept && need_div;
    assign div_req.dividend = dbytes_next;
    assign div_req.divisor  = align_reg;

    always_comb begin
        sq_next = sq_reg;
        unique case (sq_reg)
            SQ_IDLE: if (accept) sq_next = need_div ? SQ_DIV : SQ_OUT;
            SQ_DIV:  if (div_rsp.done) sq_next = SQ_OUT;
            SQ_OUT:  if (m_ready) sq_next = SQ_IDLE;
            default: sq_next = SQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg        <= SQ_IDLE;
            ph_reg        <= PH_RIFF;
            bif_reg       <= 32'd0;
            tag_reg       <= 32'd0;
            clen_reg      <= 32'd0;
            fsh_reg       <= 32'd0;
            xsz_reg       <= 16'd0;
            fmt_seen_reg  <= 1'b0;
            data_seen_reg <= 1'b0;
            dbytes_reg    <= 32'd0;
            st_reg        <= wrh_pkg::ST_PARSING;
            ftag_reg      <= 16'd0;
            chan_reg      <= 16'd0;
            rate_reg      <= 32'd0;
            brate_reg     <= 32'd0;
            align_reg     <= 16'd0;
            bits_reg      <= 16'd0;
            vbits_reg     <= 16'd0;
            mask_reg      <= 32'd0;
            frames_reg    <= 32'd0;
            sbyte_reg     <= 8'd0;
            svalid_reg    <= 1'b0;
        end else begin
            sq_reg        <= sq_next;
            ph_reg        <= ph_next;
            bif_reg       <= bif_next;
            tag_reg       <= tag_next;
            clen_reg      <= clen_next;
            fsh_reg       <= fsh_next;
            xsz_reg       <= xsz_next;
            fmt_seen_reg  <= fmt_seen_next;
            data_seen_reg <= data_seen_next;
            dbytes_reg    <= dbytes_next;
            st_reg        <= st_next;
            ftag_reg      <= ftag_next;
            chan_reg      <= chan_next;
            rate_reg      <= rate_next;
            brate_reg     <= brate_next;
            align_reg     <= align_next;
            bits_reg      <= bits_next;
            vbits_reg     <= vbits_next;
            mask_reg      <= mask_next;
            frames_reg    <= frames_next;
            sbyte_reg     <= sbyte_next;
            svalid_reg    <= svalid_next;
        end
    end

    always_comb begin
        m_data.sample_byte       = sbyte_reg;
        m_data.sample_valid      = svalid_reg;
        m_data.parse_status      = st_reg;
        m_data.format_tag        = ftag_reg;
        m_data.channel_count     = chan_reg;
        m_data.sample_rate       = rate_reg;
        m_data.byte_rate         = brate_reg;
        m_data.block_align       = align_reg;
        m_data.sample_bits       = bits_reg;
        m_data.valid_sample_bits = vbits_reg;
        m_data.speaker_mask      = mask_reg;
        m_data.frame_total       = frames_reg;
    end

    // a finished verdict never changes
    `WRH_ASSERT_NEXT(a_status_sticky, aclk, aresetn, st_reg != wrh_pkg::ST_PARSING, $stable(st_reg))
    // the divider only runs while a result waits for its quotient
    `WRH_ASSERT_IMPL(a_div_only_waiting, aclk, aresetn, div_rsp.busy, sq_reg == SQ_DIV)
    // the input is never taken while a result is pending
    `WRH_ASSERT_IMPL(a_no_accept_pending, aclk, aresetn, m_valid, !s_ready)

endmodule
